[rtl/rcpd_pkg.sv]
// Shared types and constants for the RC pulse decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcpd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_RANGE = 2'd0,
		REG_AGE_LIMIT   = 2'd1,
		REG_MIN_WIDTH   = 2'd2,
		REG_MAX_WIDTH   = 2'd3
	} cfg_reg_t;

	localparam logic [14:0] SCALE_RANGE_RST = 15'd1000;
	localparam logic [9:0]  AGE_LIMIT_RST   = 10'd200;
	localparam logic [15:0] MIN_WIDTH_RST   = 16'd800;
	localparam logic [15:0] MAX_WIDTH_RST   = 16'd2200;

	localparam logic [15:0] MID_WIDTH = 16'd1500;
	localparam logic [15:0] DEAD_ZONE = 16'd40;
	localparam logic [15:0] SPAN      = 16'd460;
	localparam logic [9:0]  AGE_MAX   = 10'd1023;

	// ceil(2^36 / 460): exact floor division by 460 for dividends below 2^24
	localparam logic [27:0] RECIP_K     = 28'd149390167;
	localparam int          RECIP_SHIFT = 36;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic        mode;
		logic [15:0] capture_count;
	} in_item_t;

	typedef struct packed {
		logic               alive;
		logic        [15:0] width_out;
		logic signed [15:0] scaled_value;
		logic               width_accepted;
	} out_item_t;

	typedef struct packed {
		logic [14:0] scale_range;
		logic [9:0]  age_limit;
		logic [15:0] min_width;
		logic [15:0] max_width;
	} cfg_t;

	// front-to-back transaction
	typedef struct packed {
		logic        alive;
		logic [15:0] width;
		logic        accepted;
	} qent_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} qctl_t;

endpackage

`default_nettype wire

[rtl/rc_pwm_pulse_decoder.sv]
// RC servo pulse decoder top level: configuration registers, front, queue, back.
// Depends on rcpd_pkg, rcpd_front, rcpd_queue and rcpd_back.
//
// Takes one transaction per clock while in_stall is low: a capture edge
// (mode 0) or a millisecond tick (mode 1), and returns one result per
// transaction, in order. The front end updates the edge phase, pulse width
// and signal age in the cycle the transaction is accepted and queues it in
// a four-entry queue; the back end scales the width through four register
// stages (two multiplies, the second a reciprocal for the divide by 460).
// in_stall rises only when the queue is full. Write configuration only while
// no transaction is in flight.
`default_nettype none

module rc_pwm_pulse_decoder import rcpd_pkg::*; #(
	parameter int CAPTURE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item
);

	cfg_t  cfg_q;
	qent_t front_entry;
	qent_t head;
	qctl_t qctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_range <= SCALE_RANGE_RST;
			cfg_q.age_limit   <= AGE_LIMIT_RST;
			cfg_q.min_width   <= MIN_WIDTH_RST;
			cfg_q.max_width   <= MAX_WIDTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE_RANGE: cfg_q.scale_range <= cfg_data[14:0];
				REG_AGE_LIMIT:   cfg_q.age_limit   <= cfg_data[9:0];
				REG_MIN_WIDTH:   cfg_q.min_width   <= cfg_data;
				REG_MAX_WIDTH:   cfg_q.max_width   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = qctl.full;

	rcpd_front #(
		.CAPTURE_BITS(CAPTURE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_item (in_item),
		.cfg     (cfg_q),
		.q_full  (qctl.full),
		.accept  (qctl.push),
		.entry   (front_entry)
	);

	rcpd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (qctl.push),
		.pop   (qctl.pop),
		.din   (front_entry),
		.dout  (head),
		.full  (qctl.full),
		.empty (qctl.empty)
	);

	rcpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (qctl.empty),
		.scale_range(cfg_q.scale_range),
		.pop        (qctl.pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire

[rtl/rcpd_front.sv]
// Front end: accepts edge and tick transactions, updates the pulse state.
// Depends on rcpd_pkg; pushes one entry per transaction into rcpd_queue.
`default_nettype none

module rcpd_front import rcpd_pkg::*; #(
	parameter int CAPTURE_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_item,
	input  wire cfg_t     cfg,
	input  wire logic     q_full,
	output logic          accept,
	output qent_t         entry
);

	localparam int CW = CAPTURE_BITS;

	logic          phase_q;
	logic [CW-1:0] rise_q;
	logic [15:0]   width_q;
	logic [9:0]    age_q;

	logic          phase_nxt;
	logic [CW-1:0] rise_nxt;
	logic [15:0]   width_nxt;
	logic [9:0]    age_nxt;
	logic          acc_nxt;

	logic [CW+15:0] cap_ext;
	logic [CW-1:0]  cap_m;
	logic [CW-1:0]  diff;
	logic [CW+15:0] diff_ext;
	logic [CW+15:0] min_ext;
	logic [CW+15:0] max_ext;
	logic           in_window;

	assign accept   = in_valid && !q_full;
	assign cap_ext  = {{CW{1'b0}}, in_item.capture_count};
	assign cap_m    = cap_ext[CW-1:0];
	assign diff     = cap_m - rise_q;
	assign diff_ext = {16'd0, diff};
	assign min_ext  = {{CW{1'b0}}, cfg.min_width};
	assign max_ext  = {{CW{1'b0}}, cfg.max_width};
	assign in_window = (diff_ext >= min_ext) && (diff_ext <= max_ext);

	always_comb begin
		phase_nxt = phase_q;
		rise_nxt  = rise_q;
		width_nxt = width_q;
		age_nxt   = age_q;
		acc_nxt   = 1'b0;
		if (in_item.mode) begin
			if (age_q != AGE_MAX) begin
				age_nxt = age_q + 10'd1;
			end
		end else if (!phase_q) begin
			rise_nxt  = cap_m;
			phase_nxt = 1'b1;
		end else begin
			phase_nxt = 1'b0;
			if (in_window) begin
				width_nxt = diff_ext[15:0];
				age_nxt   = '0;
				acc_nxt   = 1'b1;
			end
		end
	end

	assign entry.alive    = age_nxt < cfg.age_limit;
	assign entry.width    = width_nxt;
	assign entry.accepted = acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			rise_q  <= '0;
			width_q <= MID_WIDTH;
			age_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			rise_q  <= rise_nxt;
			width_q <= width_nxt;
			age_q   <= age_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/rcpd_queue.sv]
// Short register queue between front and back end.
// Depends on rcpd_pkg for the entry type and depth.
`default_nettype none

module rcpd_queue import rcpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire logic  pop,
	input  wire qent_t din,
	output qent_t      dout,
	output logic       full,
	output logic       empty
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/rcpd_back.sv]
// Back end: deadband, scale by range / 460 and clamp, four register stages.
// Depends on rcpd_pkg; pops entries from rcpd_queue, drives the result port.
`default_nettype none

module rcpd_back import rcpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire qent_t head,
	input  wire logic  q_empty,
	input  wire logic  [14:0] scale_range,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output out_item_t  out_item
);

	logic en;

	// stage 1 inputs
	logic signed [16:0] d;
	logic        [16:0] ad;
	logic        [15:0] mag;
	logic               dead;

	logic        v_s1, v_s2, v_s3;
	logic        alive_s1, alive_s2, alive_s3;
	logic [15:0] width_s1, width_s2, width_s3;
	logic        acc_s1, acc_s2, acc_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic        zero_s1, zero_s2, zero_s3;
	logic        sat_s1, sat_s2, sat_s3;
	logic [8:0]  mag_s1;
	logic [23:0] prod_s2;
	logic [14:0] quo_s3;

	logic [51:0] recip_prod;
	logic [14:0] mag_out;
	logic [15:0] mag_ext;

	out_item_t out_q;
	logic      out_valid_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_empty;

	assign d    = signed'({1'b0, head.width}) - signed'({1'b0, MID_WIDTH});
	assign ad   = d[16] ? 17'(-d) : 17'(d);
	assign dead = ad[15:0] < DEAD_ZONE;
	assign mag  = ad[15:0] - DEAD_ZONE;

	assign recip_prod = {28'd0, prod_s2} * {24'd0, RECIP_K};

	assign mag_out = zero_s3 ? 15'd0 : (sat_s3 ? scale_range : quo_s3);
	assign mag_ext = {1'b0, mag_out};

	always_ff @(posedge clk) begin
		if (en) begin
			alive_s1 <= head.alive;
			width_s1 <= head.width;
			acc_s1   <= head.accepted;
			neg_s1   <= d[16];
			zero_s1  <= dead || !head.alive;
			sat_s1   <= mag >= SPAN;
			mag_s1   <= mag[8:0];

			alive_s2 <= alive_s1;
			width_s2 <= width_s1;
			acc_s2   <= acc_s1;
			neg_s2   <= neg_s1;
			zero_s2  <= zero_s1;
			sat_s2   <= sat_s1;
			prod_s2  <= {15'd0, mag_s1} * {9'd0, scale_range};

			alive_s3 <= alive_s2;
			width_s3 <= width_s2;
			acc_s3   <= acc_s2;
			neg_s3   <= neg_s2;
			zero_s3  <= zero_s2;
			sat_s3   <= sat_s2;
			quo_s3   <= recip_prod[RECIP_SHIFT+14:RECIP_SHIFT];

			out_q.alive          <= alive_s3;
			out_q.width_out      <= width_s3;
			out_q.width_accepted <= acc_s3;
			out_q.scaled_value   <= neg_s3 ? signed'(16'(-mag_ext)) : signed'(mag_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

[rtl/rcpd_checker.sv]
// Port-level checks for rc_pwm_pulse_decoder, attached by bind.
// Depends on rcpd_pkg.
`default_nettype none

module rcpd_checker import rcpd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.alive |-> out_item.scaled_value == 16'sd0)
		else $error("nonzero value while signal dead");

	a_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.width_out > 16'd1460 && out_item.width_out < 16'd1540
		|-> out_item.scaled_value == 16'sd0)
		else $error("nonzero value inside deadband");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.scaled_value[15] |-> out_item.width_out <= 16'd1460)
		else $error("negative value above lower deadband edge");

endmodule

bind rc_pwm_pulse_decoder rcpd_checker u_rcpd_checker (.*);

`default_nettype wire

[verif/tb_rc_pwm_pulse_decoder.sv]
// Testbench for rc_pwm_pulse_decoder: queue-fed driver, clocked monitor, in-line predictor.
// Depends on rcpd_pkg (register names, transaction structs) and the decoder RTL.
`default_nettype none

module tb_rc_pwm_pulse_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import rcpd_pkg::*;

	localparam int CENTER_WIDTH = 1500;
	localparam int DEADBAND = 40;
	localparam int SCALE_DIV = 460;
	localparam logic [9:0] AGE_CEIL = 10'd1023;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	// decoder state and register copies
	logic [14:0] m_scale = 15'd1000;
	logic [9:0] m_timeout = 10'd200;
	logic [15:0] m_min = 16'd800;
	logic [15:0] m_max = 16'd2200;
	logic m_phase = 1'b0;
	logic [15:0] m_rise = '0;
	logic [15:0] m_width = 16'd1500;
	logic [9:0] m_age = '0;

	in_item_t pending_events[$];
	out_item_t expected_results[$];
	out_item_t expected_head;
	logic gen_phase = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;

	rc_pwm_pulse_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic out_item_t decode_step(in_item_t ev);
		out_item_t r;
		logic acc;
		logic [15:0] w;
		longint d;
		longint scl;
		longint v;
		acc = 1'b0;
		if (ev.mode) begin
			if (m_age != AGE_CEIL)
				m_age = m_age + 10'd1;
		end else if (!m_phase) begin
			m_rise = ev.capture_count;
			m_phase = 1'b1;
		end else begin
			w = ev.capture_count - m_rise;
			if (w >= m_min && w <= m_max) begin
				m_width = w;
				m_age = '0;
				acc = 1'b1;
			end
			m_phase = 1'b0;
		end
		r.alive = (m_age < m_timeout);
		r.width_out = m_width;
		r.width_accepted = acc;
		v = 0;
		if (r.alive) begin
			d = longint'(m_width) - CENTER_WIDTH;
			if (d >= DEADBAND || d <= -DEADBAND) begin
				d = (d > 0) ? d - DEADBAND : d + DEADBAND;
				scl = m_scale;
				v = (d * scl) / SCALE_DIV;
				if (v > scl)
					v = scl;
				if (v < -scl)
					v = -scl;
			end
		end
		r.scaled_value = v[15:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(decode_step(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_events.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, out_item);
					error_count++;
				end else begin
					expected_head = expected_results.pop_front();
					check_field("alive", expected_head.alive, out_item.alive);
					check_field("width_out", expected_head.width_out, out_item.width_out);
					check_field("scaled_value", $signed(expected_head.scaled_value),
						$signed(out_item.scaled_value));
					check_field("width_accepted", expected_head.width_accepted,
						out_item.width_accepted);
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	task automatic push_edge(logic [15:0] c);
		in_item_t it;
		it.mode = 1'b0;
		it.capture_count = c;
		pending_events.push_back(it);
		gen_phase = ~gen_phase;
	endtask

	task automatic push_tick();
		in_item_t it;
		it.mode = 1'b1;
		it.capture_count = 16'($urandom);
		pending_events.push_back(it);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SCALE_RANGE: m_scale = val[14:0];
			REG_AGE_LIMIT: m_timeout = val[9:0];
			REG_MIN_WIDTH: m_min = val;
			REG_MAX_WIDTH: m_max = val;
			default: ;
		endcase
	endtask

	task automatic set_idling(int sel);
		case (sel)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 74; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 74; end
			default: begin send_idle_pct = 18; recv_stall_pct = 18; end
		endcase
	endtask

	// mostly well-formed pulses with ticks, some stray edges
	task automatic gen_random(int n);
		int done;
		int sel;
		int len;
		logic [15:0] r;
		logic [15:0] w;
		done = 0;
		while (done < n) begin
			sel = $urandom_range(99, 0);
			if (sel < 55) begin
				if (gen_phase) begin
					push_edge(16'($urandom));
					done++;
				end
				case ($urandom_range(9, 0))
					5: w = m_min - 16'd1;
					6: w = m_min;
					7: w = m_max;
					8: w = m_max + 16'd1;
					9: w = 16'($urandom);
					default: w = 16'($urandom_range(int'(m_max), int'(m_min)));
				endcase
				r = 16'($urandom);
				push_edge(r);
				if ($urandom_range(4, 0) == 0) begin
					push_tick();
					done++;
				end
				push_edge(r + w);
				done += 2;
			end else if (sel < 80) begin
				if ($urandom_range(3, 0) == 0)
					len = $urandom_range(int'(m_timeout) + 2, 1);
				else
					len = $urandom_range(4, 1);
				if (len > 64)
					len = 64;
				repeat (len) push_tick();
				done += len;
			end else begin
				push_edge(16'($urandom));
				done++;
			end
		end
	endtask

	task automatic run_phase(logic [15:0] scale, logic [15:0] tmo, logic [15:0] lo,
			logic [15:0] hi, int idling, int n);
		write_reg(REG_SCALE_RANGE, scale);
		write_reg(REG_AGE_LIMIT, tmo);
		write_reg(REG_MIN_WIDTH, lo);
		write_reg(REG_MAX_WIDTH, hi);
		set_idling(idling);
		gen_random(n);
		wait_idle();
	endtask

	initial begin
		int lo;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset state, counter wrap, window edges, deadband edges, full deflection
		push_tick();
		push_edge(16'hFFF0);
		push_edge(16'h05C4);
		push_edge(16'd0);
		push_edge(16'd800);
		push_edge(16'd100);
		push_edge(16'd2300);
		push_edge(16'h8000);
		push_edge(16'h8000 + 16'd2201);
		push_edge(16'h1234);
		push_edge(16'h1234 + 16'd799);
		push_edge(16'hFFFF);
		push_edge(16'h0000);
		push_edge(16'd0);
		push_edge(16'd1541);
		push_edge(16'hAAAA);
		push_edge(16'hAAAA + 16'd1460);
		push_edge(16'h5555);
		push_edge(16'h5555 + 16'd1000);
		push_tick();
		wait_idle();

		run_phase(16'd1000, 16'd20, 16'd800, 16'd2200, 0, 50);
		run_phase(16'h7FFF, 16'd1000, 16'd0, 16'hFFFF, 1, 50);
		run_phase(16'd0, 16'd1, 16'd1000, 16'd2000, 2, 50);
		run_phase(16'd500, 16'd8, 16'd1500, 16'd1500, 3, 50);
		// masked writes: full scale, zero timeout; empty window
		run_phase(16'hFFFF, 16'hFC00, 16'd2200, 16'd800, 0, 50);
		lo = $urandom_range(1500, 500);
		run_phase(16'($urandom_range(32767, 0)), 16'($urandom_range(60, 1)), 16'(lo),
			16'(lo + $urandom_range(1500, 0)), 2, 50);
		lo = $urandom_range(1500, 500);
		run_phase(16'($urandom_range(32767, 0)), 16'($urandom_range(60, 1)), 16'(lo),
			16'(lo + $urandom_range(1500, 0)), 3, 50);

		// high timeout and age saturation
		run_phase(16'd1000, 16'd1000, 16'd800, 16'd2200, 3, 0);
		push_edge(16'd0);
		push_edge(16'd1700);
		repeat (1030) push_tick();
		push_edge(16'd200);
		push_edge(16'd1400);
		push_tick();
		wait_idle();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

[rc_pwm_pulse_decoder.f]
rtl/rcpd_pkg.sv
rtl/rcpd_front.sv
rtl/rcpd_queue.sv
rtl/rcpd_back.sv
rtl/rc_pwm_pulse_decoder.sv
rtl/rcpd_checker.sv
verif/tb_rc_pwm_pulse_decoder.sv
